### rtl/mwmff_pkg.sv
// ----------------------------------------------------------------------------
// mwmff_pkg
// Shared types and constants for the maze wall map flood fill block.
// ----------------------------------------------------------------------------
package mwmff_pkg;

  localparam int unsigned MazeWidth  = 16;
  localparam int unsigned MazeHeight = 16;
  localparam int unsigned Cells      = 256;
  localparam int unsigned AddrW      = 8;

  localparam logic [7:0] DistNone = 8'd255;
  localparam logic [3:0] CentreLo = 4'd7;
  localparam logic [3:0] CentreHi = 4'd8;

  localparam logic [1:0] DirN = 2'd0;
  localparam logic [1:0] DirE = 2'd1;
  localparam logic [1:0] DirS = 2'd2;
  localparam logic [1:0] DirW = 2'd3;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_OBSERVE = 2'd1,
    OP_FLOOD   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    REG_GOAL_X = 1'b0,
    REG_GOAL_Y = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_OBS_RD,
    ST_OBS_WR,
    ST_MIR_RD,
    ST_MIR_WR,
    ST_FL_INIT,
    ST_FL_SEED,
    ST_CELL_RD,
    ST_NB_RD,
    ST_NB_CHK,
    ST_RES_RD,
    ST_RES,
    ST_OUT
  } state_e;

  function automatic logic [4:0] reset_walls(logic [3:0] x, logic [3:0] y);
    logic [4:0] w;
    w = 5'd0;
    if (y == 4'(MazeHeight - 1)) w[DirN] = 1'b1;
    if (x == 4'(MazeWidth - 1))  w[DirE] = 1'b1;
    if (y == 4'd0)               w[DirS] = 1'b1;
    if (x == 4'd0)               w[DirW] = 1'b1;
    return w;
  endfunction

endpackage

### rtl/maze_wall_map_flood_fill.sv
// ----------------------------------------------------------------------------
// maze_wall_map_flood_fill
// Wall map and flood fill distance map of a 16x16 maze, sequenced over
// one shared read address.
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tdata: operation,cell_x,cell_y,heading,wall_front,wall_right,
//                wall_left,dest_x,dest_y,speed_run
// m_axis    out  tdata: cell_in_grid,cell_walls,cell_distance
// apb       in   goal_x at 0x0, goal_y at 0x4
// Read returns one cell. Observe reads, writes and mirrors the cell's walls. Clear
// rewrites every cell. Flood loads the seeds, then sweeps all 256 cells, skipping
// unreached ones, until a sweep changes nothing, then reads the result.
// Reset clears the maps by a pass over every cell before the first word is taken.
// A result waits in the output register while the next word is taken; the
// sequencer holds in its last state until that register is free.
// ----------------------------------------------------------------------------
module maze_wall_map_flood_fill import mwmff_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] operation [5:2] cell_x [9:6] cell_y [11:10] heading [12] wall_front
  // [13] wall_right [14] wall_left [18:15] dest_x [22:19] dest_y
  // [23] speed_run
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] cell_in_grid [5:1] cell_walls [13:6] cell_distance [15:14] zero
  output logic [15:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0] wall_mem [Cells];
  logic [7:0] dist_mem [Cells];

  state_e     state_q, state_d;
  logic [3:0] gx_q, gy_q;
  logic [23:0] item_q;
  logic [AddrW:0] cnt_q, cnt_d;
  logic [1:0] dir_q, dir_d;
  logic [4:0] here_w_q, here_w_d;
  logic [7:0] here_d_q, here_d_d;
  logic       chg_q, chg_d;
  logic [15:0] out_q;
  logic       ovalid_q;
  logic       out_load;

  logic       w_we, d_we;
  logic [AddrW-1:0] w_wa, d_wa, ra;
  logic [4:0] w_wd, w_rd_q;
  logic [7:0] d_wd, d_rd_q;

  op_e        op;
  logic [3:0] cx, cy, tx, ty;
  logic [1:0] hd;
  logic       spd;
  logic [3:0] nx, ny;
  logic       nb_ok;
  logic       centre;
  logic [7:0] nd;

  assign op  = op_e'(item_q[1:0]);
  assign cx  = item_q[5:2];
  assign cy  = item_q[9:6];
  assign hd  = item_q[11:10];
  assign tx  = item_q[18:15];
  assign ty  = item_q[22:19];
  assign spd = item_q[23];
  assign centre = (gx_q == CentreLo) && (gy_q == CentreLo) &&
                  ((tx == CentreLo) || (tx == CentreHi)) &&
                  ((ty == CentreLo) || (ty == CentreHi));
  assign nd = here_d_q + 8'd1;
  assign out_load = (state_q == ST_OUT) && (!ovalid_q || m_axis_tready);

  logic [3:0] ux, uy;
  assign ux = (state_q inside {ST_MIR_RD, ST_MIR_WR}) ? cx : cnt_q[3:0];
  assign uy = (state_q inside {ST_MIR_RD, ST_MIR_WR}) ? cy : cnt_q[7:4];

  always_comb begin
    nx = ux;
    ny = uy;
    nb_ok = 1'b1;
    case (dir_q)
      DirN: begin ny = uy + 4'd1; nb_ok = (uy != 4'(MazeHeight - 1)); end
      DirE: begin nx = ux + 4'd1; nb_ok = (ux != 4'(MazeWidth - 1)); end
      DirS: begin ny = uy - 4'd1; nb_ok = (uy != 4'd0); end
      default: begin nx = ux - 4'd1; nb_ok = (ux != 4'd0); end
    endcase
  end

  assign pready = 1'b1;
  always_comb begin
    prdata = 32'd0;
    if (paddr[2]) prdata[3:0] = gy_q;
    else prdata[3:0] = gx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gx_q <= 4'd7;
      gy_q <= 4'd7;
    end else if (psel && penable && pwrite) begin
      if (reg_e'(paddr[2]) == REG_GOAL_X) gx_q <= pwdata[3:0];
      else gy_q <= pwdata[3:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_we) wall_mem[w_wa] <= w_wd;
    if (d_we) dist_mem[d_wa] <= d_wd;
    w_rd_q <= wall_mem[ra];
    d_rd_q <= dist_mem[ra];
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    dir_d = dir_q;
    here_w_d = here_w_q;
    here_d_d = here_d_q;
    chg_d = chg_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cnt_d = '0;
          dir_d = DirN;
          unique case (op_e'(s_axis_tdata[1:0]))
            OP_READ:    state_d = ST_RES_RD;
            OP_OBSERVE: state_d = ST_OBS_RD;
            OP_FLOOD:   state_d = ST_FL_INIT;
            default:    state_d = ST_CLEAR;
          endcase
        end
      end
      ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (AddrW+1)'(Cells - 1)) state_d = (op == OP_CLEAR) ? ST_RES_RD : ST_IDLE;
      end
      ST_OBS_RD: state_d = ST_OBS_WR;
      ST_OBS_WR: begin
        here_w_d = w_rd_q | 5'b10000;
        if (item_q[12]) here_w_d[hd] = 1'b1;
        if (item_q[13]) here_w_d[hd + 2'd1] = 1'b1;
        if (item_q[14]) here_w_d[hd + 2'd3] = 1'b1;
        dir_d = DirN;
        state_d = ST_MIR_RD;
      end
      ST_MIR_RD: state_d = ST_MIR_WR;
      ST_MIR_WR: begin
        dir_d = dir_q + 2'd1;
        if (dir_q == DirW) state_d = ST_RES_RD;
        else state_d = ST_MIR_RD;
      end
      ST_FL_INIT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (AddrW+1)'(Cells - 1)) state_d = ST_FL_SEED;
      end
      ST_FL_SEED: begin
        cnt_d = '0;
        chg_d = 1'b0;
        state_d = ST_CELL_RD;
      end
      ST_CELL_RD: begin
        cnt_d = cnt_q;
        state_d = ST_NB_RD;
        dir_d = DirN;
      end
      ST_NB_RD: begin
        if (dir_q == DirN) begin
          here_w_d = w_rd_q;
          here_d_d = d_rd_q;
        end
        if ((dir_q == DirN && d_rd_q == DistNone) ||
            (dir_q != DirN && here_d_q == DistNone)) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == (AddrW+1)'(Cells - 1)) begin
            cnt_d = '0;
            state_d = chg_q ? ST_FL_SEED : ST_RES_RD;
            chg_d = 1'b0;
            if (chg_q) state_d = ST_CELL_RD;
          end else state_d = ST_CELL_RD;
        end else state_d = ST_NB_CHK;
      end
      ST_NB_CHK: begin
        if (!here_w_q[dir_q] && nb_ok && !(spd && !w_rd_q[4]) && d_rd_q > nd)
          chg_d = 1'b1;
        dir_d = dir_q + 2'd1;
        if (dir_q == DirW) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == (AddrW+1)'(Cells - 1)) begin
            cnt_d = '0;
            if (chg_d) begin
              chg_d = 1'b0;
              state_d = ST_CELL_RD;
            end else state_d = ST_RES_RD;
          end else state_d = ST_CELL_RD;
        end else state_d = ST_NB_RD;
      end
      ST_RES_RD: state_d = ST_RES;
      ST_RES:    state_d = ST_OUT;
      ST_OUT: begin
        if (!ovalid_q || m_axis_tready) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    w_we = 1'b0;
    d_we = 1'b0;
    w_wa = cnt_q[AddrW-1:0];
    d_wa = cnt_q[AddrW-1:0];
    w_wd = reset_walls(cnt_q[3:0], cnt_q[7:4]);
    d_wd = DistNone;
    ra   = {cy, cx};
    unique case (state_q)
      ST_CLEAR: begin
        w_we = 1'b1;
        d_we = 1'b1;
      end
      ST_OBS_WR: begin
        w_we = 1'b1;
        w_wa = {cy, cx};
        w_wd = here_w_d;
      end
      ST_MIR_RD: ra = {ny, nx};
      ST_MIR_WR: begin
        w_wa = {ny, nx};
        w_wd = w_rd_q | (5'd1 << (dir_q + 2'd2));
        w_we = here_w_q[dir_q] && nb_ok;
      end
      ST_FL_INIT: begin
        d_we = 1'b1;
        if (centre) begin
          if ((cnt_q[3:0] == CentreLo || cnt_q[3:0] == CentreHi) &&
              (cnt_q[7:4] == CentreLo || cnt_q[7:4] == CentreHi)) d_wd = 8'd0;
        end else if (cnt_q[3:0] == tx && cnt_q[7:4] == ty) d_wd = 8'd0;
      end
      ST_CELL_RD: ra = cnt_q[AddrW-1:0];
      ST_NB_RD: ra = {ny, nx};
      ST_NB_CHK: begin
        d_wa = {ny, nx};
        d_wd = nd;
        d_we = !here_w_q[dir_q] && nb_ok && !(spd && !w_rd_q[4]) && d_rd_q > nd;
        ra = {ny, nx};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      cnt_q    <= '0;
      dir_q    <= DirN;
      chg_q    <= 1'b0;
      ovalid_q <= 1'b0;
      item_q   <= 24'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      dir_q   <= dir_d;
      chg_q   <= chg_d;
      if (state_q == ST_IDLE && s_axis_tvalid) item_q <= s_axis_tdata;
      if (out_load) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    here_w_q <= here_w_d;
    here_d_q <= here_d_d;
    if (out_load) out_q <= {2'b00, d_rd_q, w_rd_q, 1'b1};
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;

endmodule

### tb/maze_wall_map_flood_fill_tb.sv
// ----------------------------------------------------------------------------
// maze_wall_map_flood_fill_tb
// Drives maze map words (read, observe, flood, clear) through the input
// stream and checks every result word against a behavioral map and flood-fill
// predictor or preset values. Goal registers are set over APB between phases.
// ----------------------------------------------------------------------------
module maze_wall_map_flood_fill_tb;
  import mwmff_pkg::*;

  typedef struct {
    op_e        op;
    logic [3:0] cx, cy;
    logic [1:0] hd;
    logic       wf, wr, wl;
    logic [3:0] tx, ty;
    logic       sr;
    logic       has_exp;
    logic       e_in;
    logic [4:0] e_walls;
    logic [7:0] e_dist;
  } maze_word_t;

  typedef struct {
    logic       in_grid;
    logic [4:0] walls;
    logic [7:0] steps;
  } cell_view_t;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  logic [4:0] walls_m [256];
  logic [7:0] dist_m  [256];
  logic [3:0] goal_x, goal_y;
  cell_view_t cell_q[$];
  maze_word_t dir_rows[$];
  int errors, n_results, hold_cnt, burst_left;
  int mx, my;

  maze_wall_map_flood_fill DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #500000000;
    $display("FAILURE");
    $finish;
  end

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, n_results);
    errors++;
  endtask

  function automatic void maps_reset();
    for (int i = 0; i < 256; i++) begin
      walls_m[i] = 5'd0;
      dist_m[i]  = DistNone;
      if (i / 16 == 15) walls_m[i][0] = 1'b1;
      if (i % 16 == 15) walls_m[i][1] = 1'b1;
      if (i / 16 == 0)  walls_m[i][2] = 1'b1;
      if (i % 16 == 0)  walls_m[i][3] = 1'b1;
    end
  endfunction

  function automatic void walls_observe(int x, int y, logic [1:0] hd, logic f, logic r,
                                        logic l);
    int k, nx, ny;
    k = x + 16 * y;
    walls_m[k][4] = 1'b1;
    if (f) walls_m[k][hd] = 1'b1;
    if (r) walls_m[k][2'(hd + 2'd1)] = 1'b1;
    if (l) walls_m[k][2'(hd + 2'd3)] = 1'b1;
    for (int d = 0; d < 4; d++) begin
      if (walls_m[k][d]) begin
        nx = x + ((d == 1) ? 1 : (d == 3) ? -1 : 0);
        ny = y + ((d == 0) ? 1 : (d == 2) ? -1 : 0);
        if (nx >= 0 && nx < 16 && ny >= 0 && ny < 16)
          walls_m[nx + 16 * ny][(d + 2) % 4] = 1'b1;
      end
    end
  endfunction

  function automatic void dist_flood(logic [3:0] tx, logic [3:0] ty, logic speed);
    bit changed;
    int nx, ny, nb, nd;
    for (int i = 0; i < 256; i++) dist_m[i] = DistNone;
    if (goal_x == CentreLo && goal_y == CentreLo && (tx == CentreLo || tx == CentreHi) &&
        (ty == CentreLo || ty == CentreHi)) begin
      dist_m[7 + 16 * 7] = 8'd0;
      dist_m[7 + 16 * 8] = 8'd0;
      dist_m[8 + 16 * 7] = 8'd0;
      dist_m[8 + 16 * 8] = 8'd0;
    end else begin
      dist_m[int'(tx) + 16 * int'(ty)] = 8'd0;
    end
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      for (int x = 0; x < 16; x++) begin
        for (int y = 0; y < 16; y++) begin
          if (dist_m[x + 16 * y] == DistNone) continue;
          nd = int'(dist_m[x + 16 * y]) + 1;
          for (int d = 0; d < 4; d++) begin
            if (walls_m[x + 16 * y][d]) continue;
            nx = x + ((d == 1) ? 1 : (d == 3) ? -1 : 0);
            ny = y + ((d == 0) ? 1 : (d == 2) ? -1 : 0);
            if (nx < 0 || nx > 15 || ny < 0 || ny > 15) continue;
            nb = nx + 16 * ny;
            if (speed && !walls_m[nb][4]) continue;
            if (int'(dist_m[nb]) > nd) begin
              dist_m[nb] = 8'(nd);
              changed = 1'b1;
            end
          end
        end
      end
    end
  endfunction

  function automatic cell_view_t maze_apply(maze_word_t w);
    cell_view_t v;
    case (w.op)
      OP_OBSERVE: walls_observe(int'(w.cx), int'(w.cy), w.hd, w.wf, w.wr, w.wl);
      OP_FLOOD:   dist_flood(w.tx, w.ty, w.sr);
      OP_CLEAR:   maps_reset();
      default: ;
    endcase
    v.in_grid = 1'b1;
    v.walls   = walls_m[int'(w.cx) + 16 * int'(w.cy)];
    v.steps   = dist_m[int'(w.cx) + 16 * int'(w.cy)];
    return v;
  endfunction

  function automatic maze_word_t mk(op_e op, int cx, int cy, int hd, int f, int r, int l,
                                    int tx, int ty, int sr, int he = 0, int ew = 0,
                                    int ed = 0);
    maze_word_t w;
    w.op = op; w.cx = 4'(cx); w.cy = 4'(cy); w.hd = 2'(hd);
    w.wf = 1'(f); w.wr = 1'(r); w.wl = 1'(l);
    w.tx = 4'(tx); w.ty = 4'(ty); w.sr = 1'(sr);
    w.has_exp = 1'(he); w.e_in = 1'b1; w.e_walls = 5'(ew); w.e_dist = 8'(ed);
    return w;
  endfunction

  function automatic maze_word_t random_word();
    maze_word_t w;
    int r, d;
    w = mk(OP_READ, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 3),
           $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
           $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 50) begin
      w.op = OP_OBSERVE; w.cx = 4'(mx); w.cy = 4'(my);
      d = $urandom_range(0, 3);
      w.hd = 2'(d);
      if (d == 0 && my < 15) my++;
      if (d == 1 && mx < 15) mx++;
      if (d == 2 && my > 0) my--;
      if (d == 3 && mx > 0) mx--;
    end else if (r < 65) begin
      w.op = OP_READ;
    end else if (r < 80) begin
      w.op = OP_FLOOD;
      if ($urandom_range(0, 1)) begin
        w.tx = 4'($urandom_range(7, 8));
        w.ty = 4'($urandom_range(7, 8));
      end
    end else if (r < 85) begin
      w.op = OP_CLEAR;
    end else begin
      w.op = op_e'($urandom_range(0, 3));
      if (w.op == OP_FLOOD && $urandom_range(0, 1)) w.op = OP_READ;
    end
    return w;
  endfunction

  task automatic send_word(maze_word_t w);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {w.sr, w.ty, w.tx, w.wl, w.wr, w.wf, w.hd, w.cy, w.cx, w.op};
    do @(posedge clk_i); while (!s_axis_tready);
    if (w.has_exp) begin
      void'(maze_apply(w));
      cell_q.push_back('{w.e_in, w.e_walls, w.e_dist});
    end else begin
      cell_q.push_back(maze_apply(w));
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (cell_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic reg_write(reg_e idx, logic [3:0] val);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = 3'(int'(idx) * 4);
    pwdata = 32'(val);
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    pwrite = 1'b0; penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (prdata[3:0] !== val) report("register readback", int'(prdata[3:0]), int'(val));
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
    if (idx == REG_GOAL_X) goal_x = val;
    else goal_y = val;
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready = 1'b0;
      end else begin
        case (($urandom_range(0, 255) + n_results) % 3)
          0: m_axis_tready = 1'b1;
          1: m_axis_tready = $urandom_range(0, 1);
          default: m_axis_tready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cell_q.size() == 0) begin
        report("unexpected word", int'(m_axis_tdata), 0);
      end else begin
        if (m_axis_tdata[0] !== cell_q[0].in_grid)
          report("cell_in_grid", int'(m_axis_tdata[0]), int'(cell_q[0].in_grid));
        if (m_axis_tdata[5:1] !== cell_q[0].walls)
          report("cell_walls", int'(m_axis_tdata[5:1]), int'(cell_q[0].walls));
        if (m_axis_tdata[13:6] !== cell_q[0].steps)
          report("cell_distance", int'(m_axis_tdata[13:6]), int'(cell_q[0].steps));
        void'(cell_q.pop_front());
      end
      n_results++;
      if (n_results == 20) hold_cnt = 3000;
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errors = 0; n_results = 0; hold_cnt = 0; burst_left = 0;
    mx = 0; my = 0; goal_x = 4'd7; goal_y = 4'd7;
    maps_reset();
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    dir_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 5'b01100, 255));
    dir_rows.push_back(mk(OP_READ, 15, 15, 0, 0, 0, 0, 0, 0, 0, 1, 5'b00011, 255));
    dir_rows.push_back(mk(OP_OBSERVE, 3, 3, 0, 1, 1, 1, 0, 0, 0, 1, 5'b11011, 255));
    dir_rows.push_back(mk(OP_OBSERVE, 4, 4, 1, 1, 0, 0, 15, 15, 1));
    dir_rows.push_back(mk(OP_OBSERVE, 5, 5, 2, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk(OP_OBSERVE, 6, 6, 3, 0, 0, 1, 0, 0, 0));
    dir_rows.push_back(mk(OP_OBSERVE, 0, 15, 3, 1, 1, 1, 0, 0, 0));
    dir_rows.push_back(mk(OP_READ, 3, 4, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(OP_FLOOD, 7, 8, 0, 0, 0, 0, 8, 7, 0, 1, 5'b00000, 0));
    dir_rows.push_back(mk(OP_FLOOD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 5'b01100, 0));
    dir_rows.push_back(mk(OP_READ, 15, 15, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(OP_FLOOD, 4, 4, 0, 0, 0, 0, 3, 3, 1));
    dir_rows.push_back(mk(OP_FLOOD, 15, 0, 0, 0, 0, 0, 15, 15, 1, 1, 5'b00110, 255));
    dir_rows.push_back(mk(OP_CLEAR, 15, 0, 0, 0, 0, 0, 0, 0, 0, 1, 5'b00110, 255));
    dir_rows.push_back(mk(OP_READ, 3, 3, 0, 0, 0, 0, 0, 0, 0, 1, 5'b00000, 255));
    foreach (dir_rows[i]) send_word(dir_rows[i]);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin reg_write(REG_GOAL_X, 4'd7);  reg_write(REG_GOAL_Y, 4'd7);  end
        1: begin reg_write(REG_GOAL_X, 4'd0);  reg_write(REG_GOAL_Y, 4'd0);  end
        2: begin reg_write(REG_GOAL_X, 4'd15); reg_write(REG_GOAL_Y, 4'd15); end
        default: begin
          reg_write(REG_GOAL_X, 4'd7);
          reg_write(REG_GOAL_Y, 4'($urandom_range(8, 14)));
        end
      endcase
      repeat (35) send_word(random_word());
      drain();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
rtl/mwmff_pkg.sv
rtl/maze_wall_map_flood_fill.sv
tb/maze_wall_map_flood_fill_tb.sv
